// ----- hdl/mer_pkg.sv -----
// Shared widths, codes and types for the midpoint ellipse rasterizer.
// No dependencies; used by mer_pixel_out and the top level.
package mer_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CENTER_BITS    = 12;
    localparam int RADIUS_BITS    = 11;
    localparam int SQ_BITS        = 2 * RADIUS_BITS;
    localparam int PIX_BITS       = 14;
    localparam int DEC_BITS       = 48;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // One pixel request from the sequencer to the output register
    typedef struct packed {
        logic load;
        logic neg_x;
        logic neg_y;
        logic last;
        logic fin;
    } pix_req_t;

endpackage

// ----- hdl/mer_serial_mul.sv -----
// Shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; product is taken modulo 2^PW, optionally negated.
module mer_serial_mul #(
    parameter int PW = 48,
    parameter int BW = 22
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          neg,
    input  logic [PW-1:0] mcand,
    input  logic [BW-1:0] mplier,
    output logic          done,
    output logic [PW-1:0] prod
);

    logic [PW-1:0] mcand_reg, mcand_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [BW-1:0] mplier_reg, mplier_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    // Advance one multiplier bit; stop as soon as no set bits remain
    always_comb
    begin
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        neg_next    = neg_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = mcand;
            mplier_next = mplier;
            acc_next    = '0;
            neg_next    = neg;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
        end
    end

    // Hold control state under reset, datapath free-running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
    end

    assign done = done_reg;
    assign prod = neg_reg ? (PW'(0) - acc_reg) : acc_reg;

endmodule

// ----- hdl/mer_pixel_out.sv -----
// Output register for pixel transactions: forms center plus/minus offset.
// Depends on mer_pkg for widths and the pixel request struct.
module mer_pixel_out #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mer_pkg::pix_req_t                   req,
    input  logic [mer_pkg::CENTER_BITS-1:0]     center_x,
    input  logic [mer_pkg::CENTER_BITS-1:0]     center_y,
    input  logic [COORD_BITS-1:0]               px,
    input  logic signed [COORD_BITS:0]          py,
    input  logic                                out_stall,
    output logic                                can_load,
    output logic                                out_valid,
    output logic signed [mer_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [mer_pkg::PIX_BITS-1:0] pixel_y,
    output logic                                last,
    output logic                                finished
);
    import mer_pkg::*;

    localparam int SW = (COORD_BITS + 2 > PIX_BITS) ? COORD_BITS + 2 : PIX_BITS;

    logic [SW-1:0]       cx_w, cy_w, ox_w, oy_w, sx, sy;
    logic                valid_reg, valid_next;
    logic [PIX_BITS-1:0] px_reg, py_reg;
    logic                last_reg, fin_reg;

    // Form the mirrored pixel position
    assign cx_w = SW'(center_x);
    assign cy_w = SW'(center_y);
    assign ox_w = SW'(px);
    assign oy_w = SW'(py);
    assign sx   = req.neg_x ? (cx_w - ox_w) : (cx_w + ox_w);
    assign sy   = req.neg_y ? (cy_w - oy_w) : (cy_w + oy_w);

    assign can_load = !valid_reg || !out_stall;

    // Hold until taken, load when free
    always_comb
    begin
        valid_next = valid_reg;
        if (req.load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            px_reg   <= sx[PIX_BITS-1:0];
            py_reg   <= sy[PIX_BITS-1:0];
            last_reg <= req.last;
            fin_reg  <= req.fin;
        end
    end

    assign out_valid = valid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign last      = last_reg;
    assign finished  = fin_reg;

endmodule

// ----- hdl/midpoint_ellipse_rasterizer.sv -----
// Midpoint ellipse rasterizer top level: sequencer, decision update, state.
// Depends on mer_pkg, mer_serial_mul and mer_pixel_out.
//
// A load transaction (mode 0) latches center and radii and produces no
// pixels; a step transaction (mode 1) produces the four mirrored pixels of
// the current point, the fourth marked last and, at the end of the outline,
// finished; a step after the end produces none. Items are handled one at a
// time: input stall is high from the accepted item until its work is done.
// All products come from one shift-and-add multiplier that retires one
// multiplier bit per cycle and stops once no set bits remain in its
// multiplier operand. A load takes four products. A region-two step takes
// two products and a region-one step four; the step that changes region
// adds the four products of the region-two seed. A step also waits while
// the output side stalls. The last pixel of a step sits in the output
// register while the next item is already accepted.
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [mer_pkg::CENTER_BITS-1:0]     center_x,
    input  logic [mer_pkg::CENTER_BITS-1:0]     center_y,
    input  logic [mer_pkg::RADIUS_BITS-1:0]     radius_x,
    input  logic [mer_pkg::RADIUS_BITS-1:0]     radius_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mer_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [mer_pkg::PIX_BITS-1:0] pixel_y,
    output logic                                last,
    output logic                                finished
);
    import mer_pkg::*;

    localparam int QW = SQ_BITS + 2 * (COORD_BITS + 2) + 3;
    localparam int PW = (QW > DEC_BITS) ? QW : DEC_BITS;
    localparam int BW = (SQ_BITS > COORD_BITS + 2) ? SQ_BITS : COORD_BITS + 2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L_RX2,
        ST_L_RY2,
        ST_L_RX2RY,
        ST_L_RR,
        ST_L_INIT,
        ST_T_A,
        ST_T_B,
        ST_T_CMP,
        ST_SD_A1,
        ST_SD_A2,
        ST_SD_B1,
        ST_SD_B2,
        ST_SD_FIN,
        ST_CHK,
        ST_U_X,
        ST_U_Y,
        ST_U_DEC,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_E3
    } state_t;

    state_t state_reg, state_next;

    logic [CENTER_BITS-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic [RADIUS_BITS-1:0]     rx_reg, rx_next, ry_reg, ry_next;
    logic [SQ_BITS-1:0]         rx2_reg, rx2_next, ry2_reg, ry2_next;
    logic [2*SQ_BITS-1:0]       rr_reg, rr_next;
    logic [PW-1:0]              t0_reg, t0_next, t1_reg, t1_next;
    logic [COORD_BITS-1:0]      px_reg, px_next;
    logic signed [COORD_BITS:0] py_reg, py_next;
    logic [COORD_BITS:0]        nx_reg, nx_next;
    logic signed [COORD_BITS:0] ny_reg, ny_next;
    logic [DEC_BITS-1:0]        dec_reg, dec_next;
    logic                       region2_reg, region2_next;
    logic                       drawing_reg, drawing_next;
    logic                       issued_reg, issued_next;

    logic                mul_state, mul_start, mul_neg, mul_done;
    logic [PW-1:0]       mul_a, mul_prod;
    logic [BW-1:0]       mul_b;
    logic [COORD_BITS:0] seed_a, ny_mag;
    logic [COORD_BITS+1:0] seed_b, seed_b_mag;
    logic [PW-1:0]       q_sum, q_adj, q_div;
    logic [DEC_BITS-1:0] t0_dbl, t1_dbl, ry2_w, rx2_w;
    logic                dec_neg, dec_pos;
    pix_req_t            pix_req;
    logic                can_load;

    // Operands of the region-two seed and the new-point magnitude
    assign seed_a     = {px_reg, 1'b1};
    assign seed_b     = {py_reg[COORD_BITS], py_reg} - 1'b1;
    assign seed_b_mag = seed_b[COORD_BITS+1] ? ((COORD_BITS+2)'(0) - seed_b) : seed_b;
    assign ny_mag     = ny_reg[COORD_BITS] ? ((COORD_BITS+1)'(0) - ny_reg) : ny_reg;

    // Seed in quarter units, divided by four toward zero
    assign q_sum = t0_reg + (t1_reg << 2) - (PW'(rr_reg) << 2);
    assign q_adj = q_sum[PW-1] ? (q_sum + PW'(3)) : q_sum;
    assign q_div = {{2{q_adj[PW-1]}}, q_adj[PW-1:2]};

    assign t0_dbl  = {t0_reg[DEC_BITS-2:0], 1'b0};
    assign t1_dbl  = {t1_reg[DEC_BITS-2:0], 1'b0};
    assign ry2_w   = DEC_BITS'(ry2_reg);
    assign rx2_w   = DEC_BITS'(rx2_reg);
    assign dec_neg = dec_reg[DEC_BITS-1];
    assign dec_pos = !dec_reg[DEC_BITS-1] && (dec_reg != '0);

    // Select multiplier operands by state
    always_comb
    begin
        mul_state = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        unique case (state_reg)
            ST_L_RX2:
            begin
                mul_a = PW'(rx_reg);
                mul_b = BW'(rx_reg);
            end
            ST_L_RY2:
            begin
                mul_a = PW'(ry_reg);
                mul_b = BW'(ry_reg);
            end
            ST_L_RX2RY:
            begin
                mul_a = PW'(rx2_reg);
                mul_b = BW'(ry_reg);
            end
            ST_L_RR:
            begin
                mul_a = PW'(rx2_reg);
                mul_b = BW'(ry2_reg);
            end
            ST_T_A:
            begin
                mul_a = PW'(ry2_reg);
                mul_b = BW'(px_reg);
            end
            ST_T_B:
            begin
                mul_a = PW'(rx2_reg);
                mul_b = BW'(py_reg[COORD_BITS-1:0]);
            end
            ST_SD_A1:
            begin
                mul_a = PW'(ry2_reg);
                mul_b = BW'(seed_a);
            end
            ST_SD_A2:
            begin
                mul_a = t0_reg;
                mul_b = BW'(seed_a);
            end
            ST_SD_B1:
            begin
                mul_a = PW'(rx2_reg);
                mul_b = BW'(seed_b_mag);
            end
            ST_SD_B2:
            begin
                mul_a = t1_reg;
                mul_b = BW'(seed_b_mag);
            end
            ST_U_X:
            begin
                mul_a = PW'(ry2_reg);
                mul_b = BW'(nx_reg);
            end
            ST_U_Y:
            begin
                mul_a   = PW'(rx2_reg);
                mul_b   = BW'(ny_mag);
                mul_neg = ny_reg[COORD_BITS];
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
    end

    assign mul_start = mul_state && !issued_reg;

    mer_serial_mul #(
        .PW(PW),
        .BW(BW)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .neg    (mul_neg),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    // Sequence load, region test, seed, update and pixel emission
    always_comb
    begin
        state_next   = state_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        rx2_next     = rx2_reg;
        ry2_next     = ry2_reg;
        rr_next      = rr_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        dec_next     = dec_reg;
        region2_next = region2_reg;
        drawing_next = drawing_reg;
        issued_next  = issued_reg;
        pix_req      = '0;

        if (mul_start)
        begin
            issued_next = 1'b1;
        end
        else if (mul_state && mul_done)
        begin
            issued_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        cx_next      = center_x;
                        cy_next      = center_y;
                        rx_next      = radius_x;
                        ry_next      = radius_y;
                        px_next      = '0;
                        py_next      = (COORD_BITS+1)'(radius_y);
                        region2_next = 1'b0;
                        drawing_next = 1'b1;
                        state_next   = ST_L_RX2;
                    end
                    else if (drawing_reg)
                    begin
                        if (region2_reg)
                        begin
                            state_next = ST_CHK;
                        end
                        else if (py_reg < 0)
                        begin
                            state_next = ST_SD_A1;
                        end
                        else
                        begin
                            state_next = ST_T_A;
                        end
                    end
                end
            end
            ST_L_RX2:
            begin
                if (issued_reg && mul_done)
                begin
                    rx2_next   = mul_prod[SQ_BITS-1:0];
                    state_next = ST_L_RY2;
                end
            end
            ST_L_RY2:
            begin
                if (issued_reg && mul_done)
                begin
                    ry2_next   = mul_prod[SQ_BITS-1:0];
                    state_next = ST_L_RX2RY;
                end
            end
            ST_L_RX2RY:
            begin
                if (issued_reg && mul_done)
                begin
                    t0_next    = mul_prod;
                    state_next = ST_L_RR;
                end
            end
            ST_L_RR:
            begin
                if (issued_reg && mul_done)
                begin
                    rr_next    = mul_prod[2*SQ_BITS-1:0];
                    state_next = ST_L_INIT;
                end
            end
            ST_L_INIT:
            begin
                dec_next   = ry2_w - t0_reg[DEC_BITS-1:0] + DEC_BITS'(rx2_reg[SQ_BITS-1:2]);
                state_next = ST_IDLE;
            end
            ST_T_A:
            begin
                if (issued_reg && mul_done)
                begin
                    t0_next    = mul_prod;
                    state_next = ST_T_B;
                end
            end
            ST_T_B:
            begin
                if (issued_reg && mul_done)
                begin
                    t1_next    = mul_prod;
                    state_next = ST_T_CMP;
                end
            end
            ST_T_CMP:
            begin
                if (t0_reg <= t1_reg)
                begin
                    state_next = ST_CHK;
                end
                else
                begin
                    state_next = ST_SD_A1;
                end
            end
            ST_SD_A1:
            begin
                if (issued_reg && mul_done)
                begin
                    t0_next    = mul_prod;
                    state_next = ST_SD_A2;
                end
            end
            ST_SD_A2:
            begin
                if (issued_reg && mul_done)
                begin
                    t0_next    = mul_prod;
                    state_next = ST_SD_B1;
                end
            end
            ST_SD_B1:
            begin
                if (issued_reg && mul_done)
                begin
                    t1_next    = mul_prod;
                    state_next = ST_SD_B2;
                end
            end
            ST_SD_B2:
            begin
                if (issued_reg && mul_done)
                begin
                    t1_next    = mul_prod;
                    state_next = ST_SD_FIN;
                end
            end
            ST_SD_FIN:
            begin
                dec_next     = q_div[DEC_BITS-1:0];
                region2_next = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                // Drop out when the current point lies below the axis
                if (py_reg < 0)
                begin
                    drawing_next = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    if (!region2_reg)
                    begin
                        nx_next = {1'b0, px_reg} + 1'b1;
                        ny_next = dec_neg ? py_reg : (py_reg - 1'b1);
                    end
                    else
                    begin
                        ny_next = py_reg - 1'b1;
                        nx_next = dec_pos ? {1'b0, px_reg} : ({1'b0, px_reg} + 1'b1);
                    end
                    state_next = ST_U_X;
                end
            end
            ST_U_X:
            begin
                if (issued_reg && mul_done)
                begin
                    t0_next    = mul_prod;
                    state_next = ST_U_Y;
                end
            end
            ST_U_Y:
            begin
                if (issued_reg && mul_done)
                begin
                    t1_next    = mul_prod;
                    state_next = ST_U_DEC;
                end
            end
            ST_U_DEC:
            begin
                if (!region2_reg)
                begin
                    if (dec_neg)
                    begin
                        dec_next = dec_reg + t0_dbl + ry2_w;
                    end
                    else
                    begin
                        dec_next = dec_reg + t0_dbl - t1_dbl - ry2_w;
                    end
                end
                else
                begin
                    if (dec_pos)
                    begin
                        dec_next = dec_reg - t1_dbl + rx2_w;
                    end
                    else
                    begin
                        dec_next = dec_reg + t0_dbl - t1_dbl + rx2_w;
                    end
                end
                state_next = ST_E0;
            end
            ST_E0:
            begin
                if (can_load)
                begin
                    pix_req.load = 1'b1;
                    state_next   = ST_E1;
                end
            end
            ST_E1:
            begin
                pix_req.neg_x = 1'b1;
                if (can_load)
                begin
                    pix_req.load = 1'b1;
                    state_next   = ST_E2;
                end
            end
            ST_E2:
            begin
                pix_req.neg_y = 1'b1;
                if (can_load)
                begin
                    pix_req.load = 1'b1;
                    state_next   = ST_E3;
                end
            end
            ST_E3:
            begin
                pix_req.neg_x = 1'b1;
                pix_req.neg_y = 1'b1;
                pix_req.last  = 1'b1;
                pix_req.fin   = ny_reg[COORD_BITS];
                if (can_load)
                begin
                    pix_req.load = 1'b1;
                    px_next      = nx_reg[COORD_BITS-1:0];
                    py_next      = ny_reg;
                    if (ny_reg[COORD_BITS])
                    begin
                        drawing_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cx_reg      <= '0;
            cy_reg      <= '0;
            rx_reg      <= '0;
            ry_reg      <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            dec_reg     <= '0;
            region2_reg <= 1'b0;
            drawing_reg <= 1'b0;
            issued_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            rx_reg      <= rx_next;
            ry_reg      <= ry_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            dec_reg     <= dec_next;
            region2_reg <= region2_next;
            drawing_reg <= drawing_next;
            issued_reg  <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx2_reg <= rx2_next;
        ry2_reg <= ry2_next;
        rr_reg  <= rr_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    mer_pixel_out #(
        .COORD_BITS(COORD_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (pix_req),
        .center_x  (cx_reg),
        .center_y  (cy_reg),
        .px        (px_reg),
        .py        (py_reg),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last),
        .finished  (finished)
    );

endmodule
